/* rtl/dcfpc_pkg.sv */
// Package for the radio time signal pulse capture and tick time base.
// Holds beat widths, configuration register indexes and reset values.
// No dependencies.
package dcfpc_pkg;

    localparam int S_TDATA_W  = 8;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef logic [7:0] count_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICK_COUNT      = 2'd0,
        REG_SECOND_COUNT    = 2'd1,
        REG_MINUTE_COUNT    = 2'd2,
        REG_INVERT_POLARITY = 2'd3
    } cfg_index_t;

    typedef enum logic {
        MODE_TICK = 1'b0,
        MODE_SYNC = 1'b1
    } mode_t;

    localparam count_t TICK_COUNT_RST   = 8'd244;
    localparam count_t SECOND_COUNT_RST = 8'd253;
    localparam count_t MINUTE_COUNT_RST = 8'd254;
    localparam count_t COUNT_MAX        = 8'hFF;

endpackage

/* rtl/dcf_pulse_capture_timebase_core.sv */
// Top level of the radio time signal pulse capture and tick time base.
// Depends on dcfpc_pkg.
//
// Takes one beat per clock cycle while s_tready is high and returns one result
// beat per input beat, registered in a single output register; the input stays
// ready while that register is empty or being drained, so a stalled output holds
// exactly one result. All state (edge counter, captured period and pulse width,
// tick counter, sub-second phase) updates in the cycle the beat is taken.
module dcf_pulse_capture_timebase_core #(
    parameter int TICKS_PER_SECOND = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [dcfpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dcfpc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] signal_level, [1] minute_pending, [7:2] zero
    input  logic [dcfpc_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] mode
    input  logic [dcfpc_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] reload_value, [8] tick_done, [9] second_done, [17:10] period_ticks,
    // [25:18] pulse_ticks, [33:26] tick_counter, [39:34] zero
    output logic [dcfpc_pkg::M_TDATA_W-1:0]     m_tdata
);
    import dcfpc_pkg::*;

    localparam int PH_W = (TICKS_PER_SECOND > 2) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(TICKS_PER_SECOND - 1);

    count_t tick_count_reg, second_count_reg, minute_count_reg;
    logic   invert_reg;

    count_t edge_ticks_reg, edge_ticks_next;
    logic   last_level_reg, last_level_next;
    count_t period_reg, period_next;
    count_t pulse_reg, pulse_next;
    count_t tick_counter_reg, tick_counter_next;
    logic [PH_W-1:0] phase_reg, phase_next;

    logic   m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic   accept;
    mode_t  mode;
    logic   level, minute;
    count_t edge_inc, sel_count, reload;
    logic   change, tick_flag, second_flag;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign mode     = mode_t'(s_tuser[0]);
    assign level    = s_tdata[0];
    assign minute   = s_tdata[1];
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg   <= TICK_COUNT_RST;
            second_count_reg <= SECOND_COUNT_RST;
            minute_count_reg <= MINUTE_COUNT_RST;
            invert_reg       <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                REG_TICK_COUNT:      tick_count_reg   <= cfg_wdata;
                REG_SECOND_COUNT:    second_count_reg <= cfg_wdata;
                REG_MINUTE_COUNT:    minute_count_reg <= cfg_wdata;
                REG_INVERT_POLARITY: invert_reg       <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        edge_ticks_next   = edge_ticks_reg;
        last_level_next   = last_level_reg;
        period_next       = period_reg;
        pulse_next        = pulse_reg;
        tick_counter_next = tick_counter_reg;
        phase_next        = phase_reg;
        edge_inc          = (edge_ticks_reg == COUNT_MAX) ? edge_ticks_reg
                                                          : edge_ticks_reg + 8'd1;
        change            = invert_reg ? (level == last_level_reg)
                                       : (level != last_level_reg);
        tick_flag         = 1'b0;
        second_flag       = 1'b0;
        sel_count         = minute_count_reg;
        unique case (mode)
            MODE_SYNC: begin
                tick_counter_next = '0;
                phase_next        = '0;
            end
            MODE_TICK: begin
                edge_ticks_next = edge_inc;
                if (change) begin
                    last_level_next = !last_level_reg;
                    if (!last_level_reg) begin
                        period_next     = edge_inc;
                        edge_ticks_next = '0;
                    end else begin
                        pulse_next = edge_inc;
                    end
                end
                tick_counter_next = tick_counter_reg + 8'd1;
                if (tick_counter_next == 8'd0 || phase_reg == PH_LAST) begin
                    phase_next = '0;
                end else begin
                    phase_next = phase_reg + PH_W'(1);
                end
                tick_flag   = 1'b1;
                second_flag = (phase_next == '0);
                if (!second_flag) begin
                    sel_count = tick_count_reg;
                end else if (!minute) begin
                    sel_count = second_count_reg;
                end
            end
            default: ;
        endcase
        reload      = 8'd0 - sel_count;
        m_data_next = {6'd0, tick_counter_next, pulse_next, period_next,
                       second_flag, tick_flag, reload};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_ticks_reg   <= '0;
            last_level_reg   <= 1'b0;
            period_reg       <= '0;
            pulse_reg        <= '0;
            tick_counter_reg <= '0;
            phase_reg        <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (accept) begin
                edge_ticks_reg   <= edge_ticks_next;
                last_level_reg   <= last_level_next;
                period_reg       <= period_next;
                pulse_reg        <= pulse_next;
                tick_counter_reg <= tick_counter_next;
                phase_reg        <= phase_next;
                m_valid_reg      <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule
